@@ rtl/mke_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mke_pkg
// Shared types, constants and the character code table of the Morse keying
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mke_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIT_W       = 16;
  localparam int unsigned DUR_W       = 18;
  localparam int unsigned MAX_ELEMS   = 5;

  localparam logic [DIT_W-1:0] DIT_RESET = 16'd100;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  // One queued character: element count and element bits, first element in
  // the top bit, 1 meaning dit.
  typedef struct packed {
    logic [2:0] count;
    logic [4:0] elems;
  } mke_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SPACE,
    ST_GAP
  } mke_state_e;

  localparam logic [7:0] LETTER_ROM [26] = '{
    8'h50, 8'h8E, 8'h8A, 8'h6C, 8'h30, 8'h9A, 8'h64, 8'h9E, 8'h58, 8'h90,
    8'h68, 8'h96, 8'h40, 8'h48, 8'h60, 8'h92, 8'h84, 8'h74, 8'h7C, 8'h20,
    8'h78, 8'h9C, 8'h70, 8'h8C, 8'h88, 8'h86
  };

  localparam logic [7:0] DIGIT_ROM [10] = '{
    8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1
  };

  function automatic mke_job_t mke_lookup(logic [7:0] c);
    logic [7:0] code;
    logic [7:0] offs;
    mke_job_t   job;
    code = 8'h00;
    offs = 8'h00;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      offs = c - CHAR_UPPER_A;
      code = LETTER_ROM[offs[4:0]];
    end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      offs = c - CHAR_DIGIT_0;
      code = DIGIT_ROM[offs[3:0]];
    end
    job.elems = code[4:0];
    if (code[7:5] > 3'(MAX_ELEMS)) begin
      job.count = 3'(MAX_ELEMS);
    end else begin
      job.count = code[7:5];
    end
    return job;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mke_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mke_front
// Accepts characters, looks up their element codes and pushes them into the
// job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mke_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       char_code_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output mke_pkg::mke_job_t     job_o
);
  import mke_pkg::*;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  // Bytes outside A-Z and 0-9 come out with a zero count: closing gap only.
  assign job_o      = mke_lookup(char_code_i);

endmodule

`default_nettype wire

@@ rtl/mke_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mke_queue
// Short register queue of decoded jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mke_queue #(
  parameter int unsigned Depth = mke_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mke_pkg::mke_job_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output mke_pkg::mke_job_t      data_o,
  output logic                   empty_o
);
  import mke_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  mke_job_t        mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count not decremented on pop");

endmodule

`default_nettype wire

@@ rtl/mke_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mke_back
// Segment sequencer: walks the elements of one job and drives the output
// register with key-down, key-up and closing-gap segments.
// ----------------------------------------------------------------------------
`default_nettype none

module mke_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [mke_pkg::DIT_W-1:0]  dit_length_i,
  input  wire logic                       empty_i,
  input  wire mke_pkg::mke_job_t          job_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            key_down_o,
  output logic [mke_pkg::DUR_W-1:0]       duration_o,
  output logic                            last_segment_o
);
  import mke_pkg::*;

  mke_state_e        state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [4:0]        elems_q, elems_d;
  logic              out_valid_q, out_valid_d;
  logic              key_q;
  logic [DUR_W-1:0]  dur_q;
  logic              last_q;

  logic              slot_free;
  logic              emit;
  logic              seg_key;
  logic              seg_three;
  logic              seg_last;
  logic [DUR_W-1:0]  dit_one;
  logic [DUR_W-1:0]  dit_three;

  assign slot_free = !out_valid_q || out_ready_i;
  assign dit_one   = {2'b00, dit_length_i};
  assign dit_three = dit_one + {1'b0, dit_length_i, 1'b0};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    elems_d   = elems_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    seg_key   = 1'b0;
    seg_three = 1'b0;
    seg_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cnt_d   = job_i.count;
          elems_d = job_i.elems;
          state_d = (job_i.count == 3'd0) ? ST_GAP : ST_MARK;
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          emit      = 1'b1;
          seg_key   = 1'b1;
          seg_three = !elems_q[4];
          state_d   = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (slot_free) begin
          emit    = 1'b1;
          cnt_d   = cnt_q - 3'd1;
          elems_d = {elems_q[3:0], 1'b0};
          state_d = (cnt_q == 3'd1) ? ST_GAP : ST_MARK;
        end
      end
      ST_GAP: begin
        if (slot_free) begin
          emit      = 1'b1;
          seg_three = 1'b1;
          seg_last  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      elems_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      elems_q     <= elems_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      key_q  <= seg_key;
      dur_q  <= seg_three ? dit_three : dit_one;
      last_q <= seg_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_down_o     = key_q;
  assign duration_o     = dur_q;
  assign last_segment_o = last_q;

  a_gap_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GAP && slot_free |=> out_valid_o && last_segment_o && !key_down_o)
    else $error("closing gap not presented as last key-up segment");

  a_elem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK || state_q == ST_SPACE) |-> cnt_q != 3'd0 && cnt_q <= 3'(MAX_ELEMS))
    else $error("element count out of range while sending");

  // The idle state may fetch the next job while the last segment still waits.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && state_q != ST_IDLE |=> state_q == $past(state_q))
    else $error("sequencer advanced while output stalled");

endmodule

`default_nettype wire

@@ rtl/morse_keying_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keying_encoder
// Turns ASCII characters into runs of Morse keying segments, each a key-down
// or key-up interval whose length is one or three dit units.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_ready_o    char_code_i
//  out       output     out_valid_o / out_ready_i  key_down_o, duration_o,
//                                                  last_segment_o
//  cfg       input      cfg_valid_i / cfg_ready_o  cfg_dit_length_i
//
//  A character with n elements gives 2n+1 segments; the segment sequencer works on
//  one character at a time and fetches the next once its closing gap is issued.
//  The front takes a character every cycle while the job queue has room.
//  Reset sets the dit length to 100 and empties the queue; no clearing pass.
//  A stalled output holds the sequencer; input stalls only once the queue
//  is full.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_keying_encoder #(
  parameter int unsigned QueueDepth = mke_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [7:0]                 char_code_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            key_down_o,
  output logic [mke_pkg::DUR_W-1:0]       duration_o,
  output logic                            last_segment_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mke_pkg::DIT_W-1:0]  cfg_dit_length_i
);
  import mke_pkg::*;

  logic [DIT_W-1:0] dit_q;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  mke_job_t         push_job;
  mke_job_t         head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q <= DIT_RESET;
    end else if (cfg_valid_i) begin
      dit_q <= cfg_dit_length_i;
    end
  end

  mke_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  mke_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  mke_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dit_length_i   (dit_q),
    .empty_i        (empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_down_o     (key_down_o),
    .duration_o     (duration_o),
    .last_segment_o (last_segment_o)
  );

endmodule

`default_nettype wire
